// ===== rtl/core/deq_pkg.sv =====
// Shared types, constants and index helpers for the double-ended queue.
`default_nettype none

package deq_pkg;

    localparam int DEPTH       = 16;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int KIND_W      = 3;
    localparam int COUNT_OUT_W = 5;

    // Operation codes; anything else behaves as a query.
    localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BACK_PUSH  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FRONT_PUSH = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BACK_POP   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FRONT_POP  = 3'd4;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [WORD_W-1:0] t_word;

    // Returned for "no word": failed pops, empty ends.
    localparam t_word WORD_NONE = '1;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [WORD_W-1:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped_word;
        logic                     error_flag;
        logic [COUNT_OUT_W-1:0]   entry_count;
        logic                     is_empty;
        logic signed [WORD_W-1:0] front_word;
        logic signed [WORD_W-1:0] back_word;
    } t_out_item;

    // Store access for one cycle: one write, two look-ahead reads.
    typedef struct packed {
        logic  wr_en;
        t_idx  wr_idx;
        t_word wr_data;
        t_idx  rd_a_idx;
        t_idx  rd_b_idx;
    } t_store_req;

    function automatic t_idx idx_inc(input t_idx i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : t_idx'(i + 1'b1);
    endfunction

    function automatic t_idx idx_dec(input t_idx i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : t_idx'(i - 1'b1);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/deq_store.sv =====
// Ring store with one write port and two registered read ports with write forwarding.
`default_nettype none

module deq_store (
    input  wire logic              i_clk,
    input  wire deq_pkg::t_store_req i_req,
    output deq_pkg::t_word         o_rd_a,
    output deq_pkg::t_word         o_rd_b
);
    import deq_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rd_a;
    t_word r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_idx] <= i_req.wr_data;
        end
        // read data reflects this cycle's write
        if (i_req.wr_en && (i_req.wr_idx == i_req.rd_a_idx)) begin
            r_rd_a <= i_req.wr_data;
        end else begin
            r_rd_a <= r_mem[i_req.rd_a_idx];
        end
        if (i_req.wr_en && (i_req.wr_idx == i_req.rd_b_idx)) begin
            r_rd_b <= i_req.wr_data;
        end else begin
            r_rd_b <= r_mem[i_req.rd_b_idx];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

`default_nettype wire

// ===== rtl/core/double_ended_queue.sv =====
// Top level of the bounded double-ended queue of signed 32-bit words.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | into      | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//  out     | out of    | o_out_valid/ i_out_stall| o_out_item (t_out_item)
//
// One transfer in gives exactly one transfer out. Sustained rate is one item
// per cycle while the out side does not stall; each item passes the input
// register, then the result register. The queue update is a single pass of
// logic between the two, set by the store look-ahead: the words next to the front
// and back ends are read ahead, so a pop finds its new end word already registered.
// Reset (synchronous, active low) empties the queue at once; no clearing pass.
// A stall on the out side holds the result; the input register keeps taking
// transfers as long as the result register can move.
`default_nettype none

module double_ended_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire deq_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output deq_pkg::t_out_item      o_out_item
);
    import deq_pkg::*;

    // input stage
    logic      r_in_valid;
    t_in_item  r_in;

    // queue state; the end words are cached next to the store
    t_idx      r_front_idx,  n_front_idx;
    t_idx      r_back_idx,   n_back_idx;
    t_cnt      r_count,      n_count;
    t_word     r_front_word, n_front_word;
    t_word     r_back_word,  n_back_word;

    // result stage
    logic      r_out_valid;
    t_out_item r_out,        n_out;

    logic       advance;
    logic       q_empty;
    logic       q_full;
    t_word      popped;
    logic       err;
    t_word      rd_a;
    t_word      rd_b;
    t_store_req store_req;

    // An item moves into the result register whenever that register is free
    // or being drained this cycle.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    assign q_empty = (r_count == '0);
    assign q_full  = (r_count == CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    always_comb begin
        n_front_idx       = r_front_idx;
        n_back_idx        = r_back_idx;
        n_count           = r_count;
        n_front_word      = r_front_word;
        n_back_word       = r_back_word;
        popped            = WORD_NONE;
        err               = 1'b0;
        store_req.wr_en   = 1'b0;
        store_req.wr_idx  = r_back_idx;
        store_req.wr_data = r_in.data_in;

        if (advance) begin
            case (r_in.kind)
                KIND_BACK_PUSH: begin
                    if (q_full) begin
                        err = 1'b1;
                    end else begin
                        store_req.wr_en = 1'b1;
                        if (q_empty) begin
                            // lone entry sits at the front position
                            store_req.wr_idx = r_front_idx;
                            n_back_idx       = r_front_idx;
                            n_front_word     = r_in.data_in;
                        end else begin
                            store_req.wr_idx = idx_inc(r_back_idx);
                            n_back_idx       = idx_inc(r_back_idx);
                        end
                        n_back_word = r_in.data_in;
                        n_count     = r_count + 1'b1;
                    end
                end
                KIND_FRONT_PUSH: begin
                    if (q_full) begin
                        err = 1'b1;
                    end else begin
                        store_req.wr_en  = 1'b1;
                        store_req.wr_idx = idx_dec(r_front_idx);
                        n_front_idx      = idx_dec(r_front_idx);
                        if (q_empty) begin
                            n_back_idx  = idx_dec(r_front_idx);
                            n_back_word = r_in.data_in;
                        end
                        n_front_word = r_in.data_in;
                        n_count      = r_count + 1'b1;
                    end
                end
                KIND_BACK_POP: begin
                    if (q_empty) begin
                        err = 1'b1;
                    end else begin
                        popped      = r_back_word;
                        n_back_idx  = idx_dec(r_back_idx);
                        n_back_word = rd_b;   // look-ahead of the entry behind the back
                        n_count     = r_count - 1'b1;
                    end
                end
                KIND_FRONT_POP: begin
                    if (q_empty) begin
                        err = 1'b1;
                    end else begin
                        popped       = r_front_word;
                        n_front_idx  = idx_inc(r_front_idx);
                        n_front_word = rd_a;  // look-ahead of the entry after the front
                        n_count      = r_count - 1'b1;
                    end
                end
                default: begin
                    // query and unused codes leave the state alone
                end
            endcase
        end

        // look-ahead reads follow the state as it will stand after this cycle
        store_req.rd_a_idx = idx_inc(n_front_idx);
        store_req.rd_b_idx = idx_dec(n_back_idx);

        n_out.popped_word = popped;
        n_out.error_flag  = err;
        n_out.entry_count = COUNT_OUT_W'(n_count);
        n_out.is_empty    = (n_count == '0);
        n_out.front_word  = (n_count == '0) ? WORD_NONE : n_front_word;
        n_out.back_word   = (n_count == '0) ? WORD_NONE : n_back_word;
    end

    deq_store u_store (
        .i_clk  (i_clk),
        .i_req  (store_req),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_idx <= '0;
            r_back_idx  <= '0;
            r_count     <= '0;
        end else begin
            r_front_idx <= n_front_idx;
            r_back_idx  <= n_back_idx;
            r_count     <= n_count;
        end
    end

    // cached end words are only read while the queue holds entries
    always_ff @(posedge i_clk) begin
        r_front_word <= n_front_word;
        r_back_word  <= n_back_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/deq_checker.sv =====
// Port-level checks for the double-ended queue, bound to the top level.
`default_nettype none

module deq_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire deq_pkg::t_out_item o_out_item
);
    import deq_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result dropped or changed while stalled");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.is_empty == (o_out_item.entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.is_empty |->
            (o_out_item.front_word == WORD_NONE) && (o_out_item.back_word == WORD_NONE))
        else $error("empty queue shows an end word");

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.error_flag |-> (o_out_item.popped_word == WORD_NONE))
        else $error("failed operation returned a word");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.entry_count <= COUNT_OUT_W'(DEPTH)))
        else $error("entry count beyond capacity");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// ===== tb/sv/tb_double_ended_queue.sv =====
// Self-checking testbench for the double-ended queue: directed corner cases plus random traffic.
`default_nettype none

module tb_double_ended_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    // Codes outside the defined set; the block treats them as a query.
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

    localparam t_word WORD_MAX = 32'sh7FFF_FFFF;
    localparam t_word WORD_MIN = 32'sh8000_0000;

    localparam int BURST_COUNT = 23;
    localparam int BURST_LEN   = 50;

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_item  in_item    = '0;
    logic      out_stall  = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    double_ended_queue DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // When set, neither side inserts gaps or stalls (back-to-back stretches).
    bit no_idle = 1'b0;

    int mismatch_count = 0;

    // ------------------------------------------------------------------
    // Shadow deque: ring of words, front position and live entry count.
    // Only live positions are ever read, so unwritten slots never matter.
    // ------------------------------------------------------------------
    t_word shadow_ring [DEPTH];
    int    shadow_front = 0;
    int    shadow_count = 0;

    // Results owed by the block, oldest first.
    t_out_item pending_results[$];

    function automatic int shadow_back_pos();
        return (shadow_front + shadow_count - 1) % DEPTH;
    endfunction

    // Apply one operation to the shadow deque and return the result it owes.
    function automatic t_out_item predict_deque_op(input t_in_item op);
        t_out_item res;
        res.popped_word = WORD_NONE;
        res.error_flag  = 1'b0;
        case (op.kind)
            KIND_BACK_PUSH: begin
                if (shadow_count >= DEPTH) begin
                    res.error_flag = 1'b1;        // full: push dropped
                end else begin
                    shadow_ring[(shadow_front + shadow_count) % DEPTH] = op.data_in;
                    shadow_count++;
                end
            end
            KIND_FRONT_PUSH: begin
                if (shadow_count >= DEPTH) begin
                    res.error_flag = 1'b1;
                end else begin
                    shadow_front = (shadow_front == 0) ? DEPTH - 1 : shadow_front - 1;
                    shadow_ring[shadow_front] = op.data_in;
                    shadow_count++;
                end
            end
            KIND_BACK_POP: begin
                if (shadow_count == 0) begin
                    res.error_flag = 1'b1;        // empty: nothing removed
                end else begin
                    res.popped_word = shadow_ring[shadow_back_pos()];
                    shadow_count--;
                end
            end
            KIND_FRONT_POP: begin
                if (shadow_count == 0) begin
                    res.error_flag = 1'b1;
                end else begin
                    res.popped_word = shadow_ring[shadow_front];
                    shadow_front = (shadow_front + 1) % DEPTH;
                    shadow_count--;
                end
            end
            default: ;                            // query and spare codes
        endcase
        res.entry_count = COUNT_OUT_W'(shadow_count);
        res.is_empty    = (shadow_count == 0);
        if (shadow_count == 0) begin
            res.front_word = WORD_NONE;
            res.back_word  = WORD_NONE;
        end else begin
            res.front_word = shadow_ring[shadow_front];
            res.back_word  = shadow_ring[shadow_back_pos()];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Input side: optional gap, then hold the item until the transfer.
    // Inputs only change at the falling edge, once per edge.
    // ------------------------------------------------------------------
    task automatic send_op(input logic [KIND_W-1:0] kind, input t_word word);
        int        gap;
        t_out_item owed;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            @(negedge i_clk);
            in_valid = 1'b0;
        end
        @(negedge i_clk);
        in_valid        = 1'b1;
        in_item.kind    = kind;
        in_item.data_in = word;
        do @(posedge i_clk); while (in_stall);
        // Transfer took place at this edge; log what it must produce.
        owed = predict_deque_op(in_item);
        pending_results = {pending_results, owed};
    endtask

    // ------------------------------------------------------------------
    // Output side: per result, an optional random stall, then accept.
    // ------------------------------------------------------------------
    always begin : out_backpressure
        int hold;
        hold = no_idle ? 0 : $urandom_range(0, 4);
        repeat (hold) begin
            @(negedge i_clk);
            out_stall = 1'b1;
        end
        @(negedge i_clk);
        out_stall = 1'b0;
        do @(posedge i_clk); while (!(i_rst_n && out_valid));
    end

    // ------------------------------------------------------------------
    // Result checker: every transfer out against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, none pending (got %p)", $time, out_item);
                mismatch_count++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (out_item.popped_word !== want.popped_word) begin
                    $display("%0t: popped_word expected %0d got %0d",
                             $time, want.popped_word, out_item.popped_word);
                    mismatch_count++;
                end
                if (out_item.error_flag !== want.error_flag) begin
                    $display("%0t: error_flag expected %0b got %0b",
                             $time, want.error_flag, out_item.error_flag);
                    mismatch_count++;
                end
                if (out_item.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d got %0d",
                             $time, want.entry_count, out_item.entry_count);
                    mismatch_count++;
                end
                if (out_item.is_empty !== want.is_empty) begin
                    $display("%0t: is_empty expected %0b got %0b",
                             $time, want.is_empty, out_item.is_empty);
                    mismatch_count++;
                end
                if (out_item.front_word !== want.front_word) begin
                    $display("%0t: front_word expected %0d got %0d",
                             $time, want.front_word, out_item.front_word);
                    mismatch_count++;
                end
                if (out_item.back_word !== want.back_word) begin
                    $display("%0t: back_word expected %0d got %0d",
                             $time, want.back_word, out_item.back_word);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Half are full-range words; the rest are extremes and small values.
    function automatic t_word random_word();
        case ($urandom_range(0, 7))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return WORD_NONE;
            3:       return t_word'($urandom_range(0, 15));
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] random_noise_kind();
        case ($urandom_range(0, 3))
            0:       return KIND_QUERY;
            1:       return KIND_SPARE_A;
            2:       return KIND_SPARE_B;
            default: return KIND_SPARE_C;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Pops on an empty queue fail; spare codes behave as queries.
    task automatic test_empty_queue();
        send_op(KIND_BACK_POP,  WORD_MAX);
        send_op(KIND_FRONT_POP, WORD_MIN);
        send_op(KIND_SPARE_A,   WORD_MAX);
        send_op(KIND_SPARE_B,   WORD_MIN);
        send_op(KIND_SPARE_C,   WORD_NONE);
    endtask

    // Extreme words through both ends, front index wrapping below zero.
    task automatic test_word_extremes();
        send_op(KIND_BACK_PUSH,  WORD_MAX);
        send_op(KIND_FRONT_PUSH, WORD_MIN);
        send_op(KIND_QUERY,      t_word'(0));
        send_op(KIND_BACK_POP,   t_word'(0));
        send_op(KIND_FRONT_POP,  t_word'(0));
    endtask

    // Fill from both ends to capacity, then both pushes on a full queue.
    task automatic test_full_queue();
        for (int i = 0; i < DEPTH; i++) begin
            send_op((i % 2 == 0) ? KIND_BACK_PUSH : KIND_FRONT_PUSH, random_word());
        end
        send_op(KIND_BACK_PUSH,  WORD_MAX);
        send_op(KIND_FRONT_PUSH, WORD_MIN);
    endtask

    // Bursts that lean toward filling, draining, or neither, so the queue
    // keeps crossing both full and empty with the pointers wrapping.
    task automatic test_random_traffic();
        int push_pct;
        for (int b = 0; b < BURST_COUNT; b++) begin
            case (b % 3)
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            no_idle = ($urandom_range(0, 4) == 0);
            for (int n = 0; n < BURST_LEN; n++) begin
                if ($urandom_range(0, 99) < 10) begin
                    send_op(random_noise_kind(), random_word());
                end else if ($urandom_range(0, 99) < push_pct) begin
                    send_op($urandom_range(0, 1) ? KIND_BACK_PUSH : KIND_FRONT_PUSH,
                            random_word());
                end else begin
                    send_op($urandom_range(0, 1) ? KIND_BACK_POP : KIND_FRONT_POP,
                            random_word());
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, tests, drain, verdict.
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_queue();
        test_word_extremes();
        test_full_queue();
        test_random_traffic();

        @(negedge i_clk);
        in_valid = 1'b0;

        // Wait out every owed result, then keep watching for strays.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog; a correct run ends well inside this.
    initial begin
        #2_000_000;
        $display("timeout with %0d results pending", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
